// ----- rtl/crtp_pkg.sv -----
`default_nettype none
package crtp_pkg;

    localparam int WIN_DEPTH = 4;
    localparam int COORD_W = 16;
    localparam int STEP_W = 6;
    localparam int ZOOM_W = 7;
    localparam logic [ZOOM_W-1:0] ZOOM_RESET = 7'd80;
    localparam logic [23:0] RECIP_100 = 24'd10737419;
    localparam int RECIP_SH = 30;
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord [WIN_DEPTH-1:0] wx;
        t_coord [WIN_DEPTH-1:0] wy;
        logic [STEP_W-1:0] steps;
    } t_job;

endpackage
`default_nettype wire

// ----- rtl/crtp_if.sv -----
`default_nettype none
interface crtp_pt_if;
    logic valid;
    logic ready;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    modport source (output valid, output raw_x, output raw_y, input ready);
    modport sink (input valid, input raw_x, input raw_y, output ready);
endinterface

interface crtp_smp_if;
    logic valid;
    logic ready;
    logic signed [16:0] point_x;
    logic signed [16:0] point_y;
    logic [18:0] pixel_index;
    logic in_bounds;
    logic last;
    modport source (output valid, output point_x, output point_y, output pixel_index,
                    output in_bounds, output last, input ready);
    modport sink (input valid, input point_x, input point_y, input pixel_index,
                  input in_bounds, input last, output ready);
endinterface

interface crtp_cfg_if;
    logic valid;
    logic ready;
    logic [6:0] zoom_percent;
    modport source (output valid, output zoom_percent, input ready);
    modport sink (input valid, input zoom_percent, output ready);
endinterface
`default_nettype wire

// ----- rtl/crtp_queue.sv -----
`default_nettype none
module crtp_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  crtp_pkg::t_job      i_job,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_avail,
    output crtp_pkg::t_job      o_job
);

    crtp_pkg::t_job r_mem [crtp_pkg::QUEUE_DEPTH];
    logic r_wp;
    logic r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'(crtp_pkg::QUEUE_DEPTH));
    assign o_avail = (r_cnt != 2'd0);
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && o_avail) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0) - 2'((i_pop && o_avail) ? 1 : 0);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/crtp_front.sv -----
`default_nettype none
module crtp_front #(
    parameter int SCREEN_SIZE = 720,
    parameter int MAX_STEPS = 63
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    crtp_pt_if.sink             i_pt,
    crtp_cfg_if.sink            i_cfg,
    output logic                o_push,
    output crtp_pkg::t_job      o_job,
    input  wire                 i_full
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL = 3'd1;
    localparam logic [2:0] F_DIV = 3'd2;
    localparam logic [2:0] F_SHIFT = 3'd3;
    localparam logic [2:0] F_SQ = 3'd4;
    localparam logic [2:0] F_SUM = 3'd5;
    localparam logic [2:0] F_ROOT = 3'd6;
    localparam logic [2:0] F_PUSH = 3'd7;
    localparam logic signed [16:0] CTR = 17'(SCREEN_SIZE / 2);

    logic [2:0] r_st, n_st;
    logic [crtp_pkg::ZOOM_W-1:0] r_zoom;
    logic signed [15:0] r_raw [2];
    logic signed [24:0] r_prod [2];
    logic [16:0] r_q [2];
    logic r_neg [2];
    crtp_pkg::t_coord [3:0] r_wx, r_wy;
    logic [2:0] r_fill;
    logic [33:0] r_sqx, r_sqy;
    logic [35:0] r_rem, r_root, r_bit;
    logic [crtp_pkg::STEP_W-1:0] r_steps;

    logic signed [24:0] prod_c [2];
    logic [46:0] recip_c [2];
    logic signed [15:0] z_c [2];
    logic signed [16:0] dx, dy;
    logic [35:0] trial;
    logic [16:0] half_root;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            logic signed [16:0] d;
            logic [24:0] mag;
            logic signed [18:0] zz;
            d = 17'(r_raw[k]) - CTR;
            prod_c[k] = 25'(d) * $signed({18'd0, r_zoom});
            mag = r_prod[k][24] ? 25'(-r_prod[k]) : 25'(r_prod[k]);
            recip_c[k] = mag[22:0] * crtp_pkg::RECIP_100;
            zz = r_neg[k] ? 19'(CTR) - $signed({2'b00, r_q[k]})
                          : 19'(CTR) + $signed({2'b00, r_q[k]});
            if (zz > 19'sd32767) begin
                z_c[k] = 16'sh7fff;
            end else if (zz < -19'sd32768) begin
                z_c[k] = 16'sh8000;
            end else begin
                z_c[k] = zz[15:0];
            end
        end
    end

    assign dx = 17'(r_wx[2]) - 17'(r_wx[1]);
    assign dy = 17'(r_wy[2]) - 17'(r_wy[1]);
    assign trial = r_root + r_bit;
    assign half_root = r_root[17:1];

    always_comb begin
        n_st = r_st;
        case (r_st)
            F_IDLE: begin
                if (i_pt.valid) begin
                    n_st = F_MUL;
                end
            end
            F_MUL: n_st = F_DIV;
            F_DIV: n_st = F_SHIFT;
            F_SHIFT: n_st = (r_fill == 3'd4 || r_fill == 3'd3) ? F_SQ : F_IDLE;
            F_SQ: n_st = F_SUM;
            F_SUM: n_st = F_ROOT;
            F_ROOT: begin
                if (r_bit[0]) begin
                    n_st = F_PUSH;
                end
            end
            F_PUSH: begin
                if (r_bit == 36'd1 && !i_full) begin
                    n_st = F_IDLE;
                end
            end
            default: n_st = F_IDLE;
        endcase
    end

    assign i_pt.ready = (r_st == F_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_push = (r_st == F_PUSH) && (r_bit == 36'd1);
    assign o_job.wx = r_wx;
    assign o_job.wy = r_wy;
    assign o_job.steps = r_steps;

    always_ff @(posedge i_clk) begin
        if (i_pt.valid && r_st == F_IDLE) begin
            r_raw[0] <= i_pt.raw_x;
            r_raw[1] <= i_pt.raw_y;
        end
        for (int k = 0; k < 2; k++) begin
            if (r_st == F_MUL) begin
                r_prod[k] <= prod_c[k];
            end
            if (r_st == F_DIV) begin
                r_q[k] <= recip_c[k][46:crtp_pkg::RECIP_SH];
                r_neg[k] <= r_prod[k][24];
            end
        end
        if (r_st == F_SQ) begin
            r_sqx <= 34'(dx * dx);
            r_sqy <= 34'(dy * dy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= F_IDLE;
            r_zoom <= crtp_pkg::ZOOM_RESET;
            r_wx <= '0;
            r_wy <= '0;
            r_fill <= 3'd0;
            r_rem <= '0;
            r_root <= '0;
            r_bit <= '0;
            r_steps <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg.valid) begin
                r_zoom <= i_cfg.zoom_percent;
                r_wx <= '0;
                r_wy <= '0;
                r_fill <= 3'd0;
            end else if (r_st == F_SHIFT) begin
                r_wx <= {z_c[0], r_wx[3:1]};
                r_wy <= {z_c[1], r_wy[3:1]};
                if (r_fill != 3'd4) begin
                    r_fill <= r_fill + 3'd1;
                end
            end
            if (r_st == F_SUM) begin
                r_rem <= 36'(r_sqx) + 36'(r_sqy);
                r_root <= '0;
                r_bit <= 36'd1 << 34;
            end
            if (r_st == F_ROOT) begin
                if (r_rem >= trial) begin
                    r_rem <= r_rem - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            if (r_st == F_PUSH && r_bit == '0) begin
                r_bit <= 36'd1;
            end
            if (r_st == F_PUSH && r_bit == '0) begin
                if (half_root == 17'd0) begin
                    r_steps <= crtp_pkg::STEP_W'(1);
                end else if (half_root > 17'(MAX_STEPS)) begin
                    r_steps <= crtp_pkg::STEP_W'(MAX_STEPS);
                end else begin
                    r_steps <= half_root[crtp_pkg::STEP_W-1:0];
                end
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 3'd4) else $error("window fill out of range");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> r_fill == 3'd4) else $error("segment issued before window full");
    a_steps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_bit == 36'd1) |-> (r_steps >= crtp_pkg::STEP_W'(1)
        && r_steps <= crtp_pkg::STEP_W'(MAX_STEPS))) else $error("step count out of range");

endmodule
`default_nettype wire

// ----- rtl/crtp_back.sv -----
`default_nettype none
module crtp_back #(
    parameter int SCREEN_SIZE = 720
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_avail,
    input  crtp_pkg::t_job      i_job,
    output logic                o_pop,
    crtp_smp_if.source          o_smp
);

    localparam int SW = $clog2(SCREEN_SIZE + 1);
    localparam int IW = SW + 24;
    localparam logic signed [SW:0] SCR = (SW + 1)'(SCREEN_SIZE);
    localparam logic signed [IW-1:0] SS2 = IW'(SCREEN_SIZE * SCREEN_SIZE);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_DIV = 3'd1;
    localparam logic [2:0] B_MUL0 = 3'd2;
    localparam logic [2:0] B_MUL1 = 3'd3;
    localparam logic [2:0] B_ADD = 3'd4;
    localparam logic [2:0] B_IDX = 3'd5;
    localparam logic [2:0] B_OUT = 3'd6;

    logic [2:0] r_st;
    crtp_pkg::t_job r_job;
    logic [4:0] r_dcnt;
    logic [6:0] r_drem;
    logic [16:0] r_dq;
    logic [16:0] r_t;
    logic [5:0] r_frac;
    logic [crtp_pkg::STEP_W-1:0] r_i;
    logic r_ax;
    logic [1:0] r_k;
    logic signed [37:0] r_acc, r_plo, r_phi;
    logic signed [21:0] r_sx, r_sy;
    logic signed [IW-1:0] r_idx;
    logic r_ov;

    logic [6:0] drem_sh;
    logic signed [19:0] ma;
    logic signed [37:0] m_prod;
    logic signed [56:0] full;
    logic signed [56:0] sh;
    logic signed [37:0] acc_new;
    logic signed [21:0] samp;
    logic load;
    logic [6:0] frac_sum;

    function automatic logic signed [21:0] coef(input crtp_pkg::t_job j, input logic ax,
                                                input logic [1:0] k);
        logic signed [21:0] p0, p1, p2, p3;
        begin
            p0 = 22'(ax ? j.wy[0] : j.wx[0]);
            p1 = 22'(ax ? j.wy[1] : j.wx[1]);
            p2 = 22'(ax ? j.wy[2] : j.wx[2]);
            p3 = 22'(ax ? j.wy[3] : j.wx[3]);
            case (k)
                2'd0: coef = (p0 <<< 1) - 22'sd5 * p1 + (p2 <<< 2) - p3;
                2'd1: coef = p2 - p0;
                2'd2: coef = p1 <<< 1;
                default: coef = -p0 + 22'sd3 * p1 - 22'sd3 * p2 + p3;
            endcase
        end
    endfunction

    assign drem_sh = {r_drem[5:0], (r_dcnt == 5'd16)};
    assign ma = (r_st == B_MUL0) ? $signed({1'b0, r_acc[18:0]})
                                 : $signed({r_acc[37], r_acc[37:19]});
    assign m_prod = ma * $signed({1'b0, r_t});
    assign full = (57'(r_phi) <<< 19) + 57'(r_plo);
    assign sh = full >>> 16;
    assign acc_new = $signed(sh[37:0]) + $signed({coef(r_job, r_ax, r_k), 16'd0});
    always_comb begin
        logic [37:0] mag;
        mag = acc_new[37] ? 38'(-acc_new) : 38'(acc_new);
        samp = acc_new[37] ? -$signed({1'b0, mag[37:17]}) : $signed({1'b0, mag[37:17]});
    end
    assign load = (r_st == B_OUT) && (!r_ov || o_smp.ready);
    assign frac_sum = 7'(r_frac) + r_drem;
    assign o_pop = (r_st == B_IDLE) && i_avail;

    assign o_smp.valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_st == B_MUL0) begin
            r_plo <= m_prod;
        end
        if (r_st == B_MUL1) begin
            r_phi <= m_prod;
        end
        if (r_st == B_IDX) begin
            r_idx <= IW'(r_sy) * IW'(SCR) + IW'(r_sx);
        end
        if (load) begin
            o_smp.point_x <= r_sx[16:0];
            o_smp.point_y <= r_sy[16:0];
            o_smp.in_bounds <= !r_idx[IW-1] && (r_idx < SS2);
            o_smp.pixel_index <= (!r_idx[IW-1] && (r_idx < SS2)) ? r_idx[18:0] : 19'd0;
            o_smp.last <= (r_i == r_job.steps);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_ov <= 1'b0;
            r_dcnt <= '0;
            r_drem <= '0;
            r_dq <= '0;
            r_t <= '0;
            r_frac <= '0;
            r_i <= '0;
            r_ax <= 1'b0;
            r_k <= 2'd0;
            r_acc <= '0;
            r_sx <= '0;
            r_sy <= '0;
        end else begin
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_smp.ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                B_IDLE: begin
                    if (i_avail) begin
                        r_st <= B_DIV;
                        r_dcnt <= 5'd16;
                        r_drem <= '0;
                        r_dq <= '0;
                    end
                end
                B_DIV: begin
                    if (drem_sh >= 7'(r_job.steps)) begin
                        r_drem <= drem_sh - 7'(r_job.steps);
                        r_dq <= {r_dq[15:0], 1'b1};
                    end else begin
                        r_drem <= drem_sh;
                        r_dq <= {r_dq[15:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == 5'd0) begin
                        r_st <= B_MUL0;
                        r_t <= '0;
                        r_frac <= '0;
                        r_i <= '0;
                        r_ax <= 1'b0;
                        r_k <= 2'd0;
                        r_acc <= {coef(r_job, 1'b0, 2'd3), 16'd0};
                    end
                end
                B_MUL0: r_st <= B_MUL1;
                B_MUL1: r_st <= B_ADD;
                B_ADD: begin
                    r_acc <= acc_new;
                    r_st <= B_MUL0;
                    if (r_k == 2'd2) begin
                        r_k <= 2'd0;
                        if (!r_ax) begin
                            r_sx <= samp;
                            r_ax <= 1'b1;
                            r_acc <= {coef(r_job, 1'b1, 2'd3), 16'd0};
                        end else begin
                            r_sy <= samp;
                            r_st <= B_IDX;
                        end
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                B_IDX: r_st <= B_OUT;
                B_OUT: begin
                    if (load) begin
                        if (r_i == r_job.steps) begin
                            r_st <= B_IDLE;
                        end else begin
                            r_st <= B_MUL0;
                            r_i <= r_i + 1'b1;
                            r_ax <= 1'b0;
                            r_k <= 2'd0;
                            r_acc <= {coef(r_job, 1'b0, 2'd3), 16'd0};
                            if (frac_sum >= 7'(r_job.steps)) begin
                                r_frac <= 6'(frac_sum - 7'(r_job.steps));
                                r_t <= r_t + r_dq + 17'd1;
                            end else begin
                                r_frac <= frac_sum[5:0];
                                r_t <= r_t + r_dq;
                            end
                        end
                    end
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    a_t_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_OUT && r_i == r_job.steps) |-> r_t == 17'h10000)
        else $error("final sample parameter is not one");
    a_i_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != B_IDLE && r_st != B_DIV) |-> (r_i <= r_job.steps && 6'(r_frac) < r_job.steps))
        else $error("sample counter past segment");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_smp.ready) |=> r_ov) else $error("pending sample dropped");

endmodule
`default_nettype wire

// ----- rtl/catmull_rom_trace_plotter_unit.sv -----
// Catmull-Rom trace plotter. Raw points arrive on the i_pt request channel and
// are zoomed about the screen centre by the zoom register, then shifted into a
// four-entry waypoint window. Once four waypoints are held, each request yields
// steps+1 samples of the segment between the middle two on the o_smp channel,
// with x, y, linear pixel index, an in-bounds flag and a last flag on the final
// sample. Fewer than four waypoints give no samples.
// The i_cfg channel writes the zoom register and empties the window; it is
// always ready. Write it only while the block is idle; the block does not enforce this.
// The front part takes one request at a time while the window fills, zooming
// and shifting it in; with a full window it also squares, sums and takes the
// square root, and hands the segment to a two-entry queue.
// The back part first divides by the step count, then computes each sample
// with the shared multiplier, which evaluates both axes in turn.
// Reset sets the zoom to 80, empties the window and queue and drops any sample.
// When the receiver stalls, the output register holds its sample and the back
// part waits; the front part stalls once the queue is full.
`default_nettype none
module catmull_rom_trace_plotter_unit #(
    parameter int SCREEN_SIZE = 720,
    parameter int MAX_STEPS = 63
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    crtp_pt_if.sink     i_pt,
    crtp_cfg_if.sink    i_cfg,
    crtp_smp_if.source  o_smp
);

    logic push, full, pop, avail;
    crtp_pkg::t_job job_in, job_out;

    crtp_front #(.SCREEN_SIZE(SCREEN_SIZE), .MAX_STEPS(MAX_STEPS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(i_pt), .i_cfg(i_cfg),
        .o_push(push), .o_job(job_in), .i_full(full)
    );

    crtp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(job_in), .o_full(full),
        .i_pop(pop), .o_avail(avail), .o_job(job_out)
    );

    crtp_back #(.SCREEN_SIZE(SCREEN_SIZE)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(avail), .i_job(job_out),
        .o_pop(pop), .o_smp(o_smp)
    );

endmodule
`default_nettype wire
